FILE: hdl/mmlenc_pkg.sv
package mmlenc_pkg;

    // token kinds
    localparam logic [3:0] KIND_NOTE     = 4'd0;
    localparam logic [3:0] KIND_OCT_DOWN = 4'd1;
    localparam logic [3:0] KIND_OCT_UP   = 4'd2;
    localparam logic [3:0] KIND_OCT_SET  = 4'd3;
    localparam logic [3:0] KIND_TEMPO    = 4'd4;
    localparam logic [3:0] KIND_QUANT    = 4'd5;
    localparam logic [3:0] KIND_VOL      = 4'd6;
    localparam logic [3:0] KIND_CMD_E0   = 4'd7;
    localparam logic [3:0] KIND_CMD_E2   = 4'd8;
    localparam logic [3:0] KIND_NOOP     = 4'd9;
    localparam logic [3:0] KIND_LOOP     = 4'd10;
    localparam logic [3:0] KIND_END      = 4'd12;

    // note letter codes beyond A-G
    localparam logic [3:0] LETTER_REST   = 4'd7;
    localparam logic [3:0] LETTER_TIE    = 4'd8;
    localparam logic [3:0] LETTER_SETLEN = 4'd9;

    // length modes
    localparam logic [1:0] MODE_DEFAULT = 2'd0;
    localparam logic [1:0] MODE_DIV     = 2'd1;
    localparam logic [1:0] MODE_ABS     = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_INVALID  = 3'd1;
    localparam logic [2:0] ERR_ZERO_LEN = 3'd2;
    localparam logic [2:0] ERR_BAD_L    = 3'd3;
    localparam logic [2:0] ERR_OCT_LOW  = 3'd4;
    localparam logic [2:0] ERR_OCT_HIGH = 3'd5;
    localparam logic [2:0] ERR_BAD_O    = 3'd6;
    localparam logic [2:0] ERR_LOOP     = 3'd7;

    // bytecodes
    localparam logic [7:0] BC_SETLEN = 8'hc1;
    localparam logic [7:0] BC_TEMPO  = 8'hc0;
    localparam logic [7:0] BC_QUANT  = 8'hc2;
    localparam logic [7:0] BC_VOL    = 8'hcb;
    localparam logic [7:0] BC_CMD_E0 = 8'he0;
    localparam logic [7:0] BC_CMD_E2 = 8'he2;
    localparam logic [7:0] BC_END    = 8'hff;
    localparam logic [3:0] BC_LONG_HI = 4'hf;

    localparam int unsigned LEN_W      = 13;
    localparam logic [12:0] LONG_LEN   = 13'd240;
    localparam logic [12:0] MAX_SETLEN = 13'd255;

    localparam logic [3:0] OCT_MIN   = 4'd1;
    localparam logic [3:0] OCT_MAX   = 4'd8;
    localparam logic [3:0] OCT_RESET = 4'd4;
    localparam logic [7:0] DLEN_RESET = 8'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        LU_IDLE,
        LU_DIV,
        LU_DOT
    } lu_phase_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_EMIT,
        ACT_LEN
    } act_t;

    typedef struct packed {
        logic        start;
        logic        div;
        logic [11:0] operand;
        logic [2:0]  dots;
    } len_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] len;
    } len_rsp_t;

    typedef struct packed {
        act_t       act;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] n;
        logic [2:0] err;
        logic       oct_we;
        logic [3:0] oct_val;
    } dec_t;

    function automatic logic [6:0] note_pitch(input logic [3:0] letter,
                                              input logic [2:0] acc,
                                              input logic [3:0] oct);
        logic [6:0] base;
        logic [6:0] o;
        logic [6:0] sacc;
        base = 7'd0;
        o    = 7'(oct - 4'd1);
        sacc = {{4{acc[2]}}, acc};
        unique case (letter)
            4'd0:    base = 7'd9;
            4'd1:    base = 7'd11;
            4'd2:    base = 7'd0;
            4'd3:    base = 7'd2;
            4'd4:    base = 7'd4;
            4'd5:    base = 7'd5;
            4'd6:    base = 7'd7;
            default: base = 7'd0;
        endcase
        if (letter == LETTER_REST) begin
            return 7'd0;
        end else if (letter == LETTER_TIE) begin
            return 7'd1;
        end
        // octave * 12 as two shifts
        return base + sacc + (o << 3) + (o << 2);
    endfunction

endpackage

FILE: hdl/mmlenc_len.sv
module mmlenc_len
    import mmlenc_pkg::*;
#(
    parameter int TICKS_PER_WHOLE = 192
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  len_req_t req,
    output len_rsp_t rsp
);

    localparam int QW  = $clog2(TICKS_PER_WHOLE + 1);
    localparam int QCW = $clog2(QW + 1);
    localparam logic [QW-1:0] DIVIDEND = QW'(TICKS_PER_WHOLE);

    lu_phase_t        phase_reg, phase_next;
    logic [QW-1:0]    dvd_reg, dvd_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [11:0]      rem_reg, rem_next;
    logic [11:0]      divisor_reg, divisor_next;
    logic [QCW-1:0]   bcnt_reg, bcnt_next;
    logic [LEN_W-1:0] sum_reg, sum_next;
    logic [11:0]      sh_reg, sh_next;
    logic [2:0]       dcnt_reg, dcnt_next;

    logic [12:0] trial;
    logic [12:0] diff;
    logic        ge;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, dvd_reg[QW-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign ge    = trial >= {1'b0, divisor_reg};

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            LU_IDLE: begin
                if (req.start) begin
                    phase_next = req.div ? LU_DIV : LU_DOT;
                end
            end
            LU_DIV: begin
                if (bcnt_reg == QCW'(1)) begin
                    phase_next = LU_DOT;
                end
            end
            LU_DOT: begin
                if (dcnt_reg == 3'd0) begin
                    phase_next = LU_IDLE;
                end
            end
            default: phase_next = LU_IDLE;
        endcase
    end

    always_comb begin
        dvd_next     = dvd_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        bcnt_next    = bcnt_reg;
        sum_next     = sum_reg;
        sh_next      = sh_reg;
        dcnt_next    = dcnt_reg;
        unique case (phase_reg)
            LU_IDLE: begin
                if (req.start) begin
                    dvd_next     = DIVIDEND;
                    quo_next     = '0;
                    rem_next     = '0;
                    divisor_next = req.operand;
                    bcnt_next    = QCW'(QW);
                    sum_next     = {1'b0, req.operand};
                    sh_next      = req.operand;
                    dcnt_next    = req.dots;
                end
            end
            LU_DIV: begin
                dvd_next  = dvd_reg << 1;
                quo_next  = {quo_reg[QW-2:0], ge};
                rem_next  = ge ? diff[11:0] : trial[11:0];
                bcnt_next = bcnt_reg - QCW'(1);
                sum_next  = LEN_W'(quo_next);
                sh_next   = 12'(quo_next);
            end
            LU_DOT: begin
                // each dot adds half of the previous addition
                if (dcnt_reg != 3'd0) begin
                    sh_next   = sh_reg >> 1;
                    sum_next  = sum_reg + LEN_W'(sh_reg >> 1);
                    dcnt_next = dcnt_reg - 3'd1;
                end
            end
            default: ;
        endcase
    end

    assign rsp.done = (phase_reg == LU_DOT) && (dcnt_reg == 3'd0);
    assign rsp.len  = sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= LU_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        bcnt_reg    <= bcnt_next;
        sum_reg     <= sum_next;
        sh_reg      <= sh_next;
        dcnt_reg    <= dcnt_next;
    end

endmodule

FILE: hdl/mml_token_bytecode_encoder_unit.sv
// Music-macro token encoder for one track: lexed tokens in, bytecode bytes out.
// Input channel s_*: one token word per handshake (kind, letter, length, dots,
// accidental, param). Output channel m_*: one bytecode byte per word, with
// m_last on the final byte of a token and m_error_code nonzero on a fault word.
// A token is taken only while the block is idle. A note with a default length
// and no dots, a command or the end token is decoded into the byte buffer on
// acceptance; its bytes move on to the output register once it is free. A note
// with an explicit length or with dots runs the length unit first: a divisor
// length goes through a bit-serial divider of ceil(log2(TICKS_PER_WHOLE+1))
// quotient bits (8 at 192), then one dot step per dot. Bytes then leave one
// per cycle while the receiver keeps m_ready high; a token gives up to three
// bytes. Valid octave changes and noop tokens give no output word. Reset
// (aresetn low, synchronous) sets octave 4 and default length 48 and empties
// the output register. When the receiver holds m_ready low, the word stays in
// the output register and the block stops between bytes; it takes no new token
// until the last byte of the current one has entered the output register.
module mml_token_bytecode_encoder_unit
    import mmlenc_pkg::*;
#(
    parameter int TICKS_PER_WHOLE = 192,
    parameter int MAX_DOTS        = 7
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_kind,
    input  logic [3:0]  s_note_letter,
    input  logic [1:0]  s_len_mode,
    input  logic [11:0] s_length_value,
    input  logic [2:0]  s_dots,
    input  logic signed [2:0] s_accidental,
    input  logic [15:0] s_param,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic [2:0]  m_error_code
);

    state_t     state_reg, state_next;
    logic [3:0] octave_reg, octave_next;
    logic [7:0] dlen_reg, dlen_next;
    logic [3:0] letter_reg;
    logic [2:0] acc_reg;

    logic [7:0] buf0_reg, buf0_next;
    logic [7:0] buf1_reg, buf1_next;
    logic [7:0] buf2_reg, buf2_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] err_reg, err_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic       m_last_reg, m_last_next;
    logic [2:0] m_err_reg, m_err_next;

    logic     accept;
    logic     out_free;
    logic     emit_word;
    logic [2:0] dots_cl;
    dec_t     dec;
    len_req_t lreq;
    len_rsp_t lrsp;
    logic [6:0] pitch;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_word = (state_reg == ST_EMIT) && out_free;

    assign dots_cl = ({1'b0, s_dots} > 4'(MAX_DOTS)) ? 3'(MAX_DOTS) : s_dots;
    assign pitch   = note_pitch(letter_reg, acc_reg, octave_reg);

    // token decode
    always_comb begin
        dec         = '0;
        dec.act     = ACT_NONE;
        dec.err     = ERR_NONE;
        dec.oct_val = octave_reg;
        unique case (s_kind)
            KIND_NOTE: begin
                if (s_note_letter > LETTER_SETLEN || s_len_mode == 2'd3) begin
                    dec.act = ACT_EMIT; dec.n = 2'd1; dec.err = ERR_INVALID;
                end else if (s_len_mode == MODE_DIV && s_length_value == 12'd0) begin
                    dec.act = ACT_EMIT; dec.n = 2'd1; dec.err = ERR_ZERO_LEN;
                end else if (s_len_mode == MODE_DEFAULT && dots_cl == 3'd0) begin
                    dec.act = ACT_EMIT; dec.n = 2'd1;
                    if (s_note_letter == LETTER_SETLEN) begin
                        dec.err = ERR_BAD_L;
                    end else begin
                        dec.b0 = {note_pitch(s_note_letter, s_accidental, octave_reg),
                                  1'b0};
                    end
                end else begin
                    dec.act = ACT_LEN;
                end
            end
            KIND_OCT_DOWN: begin
                if (octave_reg <= OCT_MIN) begin
                    dec.act = ACT_EMIT; dec.n = 2'd1; dec.err = ERR_OCT_LOW;
                end else begin
                    dec.oct_we = 1'b1; dec.oct_val = octave_reg - 4'd1;
                end
            end
            KIND_OCT_UP: begin
                if (octave_reg >= OCT_MAX) begin
                    dec.act = ACT_EMIT; dec.n = 2'd1; dec.err = ERR_OCT_HIGH;
                end else begin
                    dec.oct_we = 1'b1; dec.oct_val = octave_reg + 4'd1;
                end
            end
            KIND_OCT_SET: begin
                if (s_param < 16'(OCT_MIN) || s_param > 16'(OCT_MAX)) begin
                    dec.act = ACT_EMIT; dec.n = 2'd1; dec.err = ERR_BAD_O;
                end else begin
                    dec.oct_we = 1'b1; dec.oct_val = s_param[3:0];
                end
            end
            KIND_TEMPO, KIND_CMD_E0, KIND_CMD_E2: begin
                dec.act = ACT_EMIT; dec.n = 2'd3;
                dec.b0  = (s_kind == KIND_TEMPO) ? BC_TEMPO :
                          (s_kind == KIND_CMD_E0) ? BC_CMD_E0 : BC_CMD_E2;
                dec.b1  = s_param[7:0];
                dec.b2  = s_param[15:8];
            end
            KIND_QUANT: begin
                dec.act = ACT_EMIT; dec.n = 2'd1; dec.b0 = BC_QUANT + s_param[7:0];
            end
            KIND_VOL: begin
                dec.act = ACT_EMIT; dec.n = 2'd1; dec.b0 = BC_VOL + s_param[7:0];
            end
            KIND_NOOP: ;
            KIND_LOOP: begin
                dec.act = ACT_EMIT; dec.n = 2'd1; dec.err = ERR_LOOP;
            end
            KIND_END: begin
                dec.act = ACT_EMIT; dec.n = 2'd1; dec.b0 = BC_END;
            end
            default: begin
                dec.act = ACT_EMIT; dec.n = 2'd1; dec.err = ERR_INVALID;
            end
        endcase
    end

    assign lreq.start   = accept && (dec.act == ACT_LEN);
    assign lreq.div     = (s_len_mode == MODE_DIV);
    assign lreq.operand = (s_len_mode == MODE_DEFAULT) ? 12'(dlen_reg) : s_length_value;
    assign lreq.dots    = dots_cl;

    mmlenc_len #(
        .TICKS_PER_WHOLE(TICKS_PER_WHOLE)
    ) u_len (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (lreq),
        .rsp    (lrsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (dec.act == ACT_EMIT) begin
                        state_next = ST_EMIT;
                    end else if (dec.act == ACT_LEN) begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                if (lrsp.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && cnt_reg == 2'd1) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        octave_next  = octave_reg;
        dlen_next    = dlen_reg;
        buf0_next    = buf0_reg;
        buf1_next    = buf1_reg;
        buf2_next    = buf2_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_err_next   = m_err_reg;

        if (accept) begin
            if (dec.oct_we) begin
                octave_next = dec.oct_val;
            end
            buf0_next = dec.b0;
            buf1_next = dec.b1;
            buf2_next = dec.b2;
            cnt_next  = dec.n;
            err_next  = dec.err;
        end

        if (state_reg == ST_LEN && lrsp.done) begin
            err_next = ERR_NONE;
            if (letter_reg == LETTER_SETLEN) begin
                if (lrsp.len > MAX_SETLEN) begin
                    buf0_next = 8'd0;
                    cnt_next  = 2'd1;
                    err_next  = ERR_BAD_L;
                end else begin
                    dlen_next = lrsp.len[7:0];
                    buf0_next = BC_SETLEN;
                    buf1_next = lrsp.len[7:0];
                    cnt_next  = 2'd2;
                end
            end else begin
                buf0_next = {pitch, 1'b1};
                if (lrsp.len < LONG_LEN) begin
                    buf1_next = lrsp.len[7:0];
                    cnt_next  = 2'd2;
                end else begin
                    buf1_next = {BC_LONG_HI, lrsp.len[11:8]};
                    buf2_next = lrsp.len[7:0];
                    cnt_next  = 2'd3;
                end
            end
        end

        if (emit_word) begin
            m_valid_next = 1'b1;
            m_byte_next  = buf0_reg;
            m_last_next  = (cnt_reg == 2'd1);
            m_err_next   = err_reg;
            buf0_next    = buf1_reg;
            buf1_next    = buf2_reg;
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_last       = m_last_reg;
    assign m_error_code = m_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            octave_reg  <= OCT_RESET;
            dlen_reg    <= DLEN_RESET;
            cnt_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            octave_reg  <= octave_next;
            dlen_reg    <= dlen_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            letter_reg <= s_note_letter;
            acc_reg    <= s_accidental;
        end
        buf0_reg   <= buf0_next;
        buf1_reg   <= buf1_next;
        buf2_reg   <= buf2_next;
        err_reg    <= err_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_err_reg  <= m_err_next;
    end

endmodule
